// File: sv/qrm_pkg.sv
// shared constants for the quaternion to rotation matrix block
`default_nettype none
package qrm_pkg;
    localparam int N_ENTRIES = 9;
    // entries that carry 1.0 in the identity matrix
    localparam logic [N_ENTRIES-1:0] IDENT_DIAG = 9'b100010001;
endpackage
`default_nettype wire

// File: sv/qrm_if.sv
// valid/ready channels for quaternion words and matrix words
`default_nettype none
interface qrm_in_if #(parameter int COMP_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] quat_x;
    logic signed [COMP_WIDTH-1:0] quat_y;
    logic signed [COMP_WIDTH-1:0] quat_z;
    logic signed [COMP_WIDTH-1:0] quat_w;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
    modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrm_out_if #(parameter int COMP_WIDTH = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COMP_WIDTH-1:0] rot_00;
    logic signed [COMP_WIDTH-1:0] rot_01;
    logic signed [COMP_WIDTH-1:0] rot_02;
    logic signed [COMP_WIDTH-1:0] rot_10;
    logic signed [COMP_WIDTH-1:0] rot_11;
    logic signed [COMP_WIDTH-1:0] rot_12;
    logic signed [COMP_WIDTH-1:0] rot_20;
    logic signed [COMP_WIDTH-1:0] rot_21;
    logic signed [COMP_WIDTH-1:0] rot_22;
    logic                         zero_length;
    modport source (output valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                    rot_20, rot_21, rot_22, zero_length, input ready);
    modport sink   (input valid, rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                    rot_20, rot_21, rot_22, zero_length, output ready);
endinterface
`default_nettype wire

// File: sv/quaternion_to_rotation_matrix.sv
// quaternion to 3x3 rotation matrix, pipelined with per-lane restoring division
// a word passes through the input, product, numerator, division and output registers
// throughput: one word per cycle; the pipeline moves as a whole and holds when
// the output register is full and not taken
// one division stage per quotient bit over nine lanes sets the depth
// reset (synchronous, active low) clears all valid bits; payload is not reset
`default_nettype none
module quaternion_to_rotation_matrix
    import qrm_pkg::*;
#(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    qrm_in_if.sink     i_quat,
    qrm_out_if.source  o_rot
);
    localparam int CW = COMP_WIDTH;
    localparam int PW = 2 * CW;       // product width
    localparam int NW = 2 * CW + 2;   // signed numerator width
    localparam int RW = 2 * CW + 2;   // remainder and length width
    localparam int QW = FRAC_BITS + 1;
    localparam int ND = FRAC_BITS + 1; // division stages
    localparam logic [QW:0] ONE_Q = (QW+1)'(1) << FRAC_BITS;

    logic en;
    assign en           = !o_rot.valid || o_rot.ready;
    assign i_quat.ready = en;

    // stage a: input registers
    logic                 r_va;
    logic signed [CW-1:0] r_x, r_y, r_z, r_w;
    // stage b: products
    logic                 r_vb;
    logic signed [PW-1:0] r_xx, r_yy, r_zz, r_ww, r_xy, r_xz, r_xw, r_yz, r_yw, r_zw;
    // division stages, index 0 is the numerator stage
    logic [ND:0]          r_vd;
    logic [RW-1:0]        r_len [ND+1];
    logic                 r_zl  [ND+1];
    logic [N_ENTRIES-1:0] r_neg [ND+1];
    logic [RW-1:0]        r_rem [ND+1][N_ENTRIES];
    logic [QW-1:0]        r_q   [ND+1][N_ENTRIES];
    logic [RW-1:0]        n_rem [ND+1][N_ENTRIES];
    logic [QW-1:0]        n_q   [ND+1][N_ENTRIES];
    logic signed [NW-1:0] n_num [N_ENTRIES];
    logic [RW-1:0]        n_len;
    logic signed [CW-1:0] n_rot [N_ENTRIES];
    logic signed [CW-1:0] r_rot [N_ENTRIES];
    logic                 r_ov, r_ozl;

    function automatic logic signed [NW-1:0] ext(input logic signed [PW-1:0] v);
        return NW'(v);
    endfunction

    always_comb begin
        n_len = RW'(ext(r_xx) + ext(r_yy) + ext(r_zz) + ext(r_ww));
        n_num[0] = ext(r_xx) + ext(r_ww) - ext(r_yy) - ext(r_zz);
        n_num[1] = (ext(r_xy) + ext(r_zw)) <<< 1;
        n_num[2] = (ext(r_xz) - ext(r_yw)) <<< 1;
        n_num[3] = (ext(r_xy) - ext(r_zw)) <<< 1;
        n_num[4] = ext(r_yy) + ext(r_ww) - ext(r_xx) - ext(r_zz);
        n_num[5] = (ext(r_yz) + ext(r_xw)) <<< 1;
        n_num[6] = (ext(r_xz) + ext(r_yw)) <<< 1;
        n_num[7] = (ext(r_yz) - ext(r_xw)) <<< 1;
        n_num[8] = ext(r_zz) + ext(r_ww) - ext(r_xx) - ext(r_yy);
    end

    // one quotient bit per stage; the first compares without doubling
    always_comb begin
        logic [RW-1:0] d;
        for (int l = 0; l < N_ENTRIES; l++) begin
            n_rem[0][l] = '0;
            n_q[0][l]   = '0;
        end
        for (int s = 0; s < ND; s++) begin
            for (int l = 0; l < N_ENTRIES; l++) begin
                d = (s == 0) ? r_rem[s][l] : (r_rem[s][l] << 1);
                if (d >= r_len[s]) begin
                    n_rem[s+1][l] = d - r_len[s];
                    n_q[s+1][l]   = {r_q[s][l][QW-2:0], 1'b1};
                end else begin
                    n_rem[s+1][l] = d;
                    n_q[s+1][l]   = {r_q[s][l][QW-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero, clamp to one, restore sign; a zero-length word gives the identity
    always_comb begin
        logic [QW:0] qr;
        for (int l = 0; l < N_ENTRIES; l++) begin
            qr = {1'b0, r_q[ND][l]} + {{QW{1'b0}}, ((r_rem[ND][l] << 1) >= r_len[ND])};
            if (qr > ONE_Q)
                qr = ONE_Q;
            if (r_zl[ND])
                n_rot[l] = IDENT_DIAG[l] ? CW'(ONE_Q) : '0;
            else if (r_neg[ND][l])
                n_rot[l] = -CW'(qr);
            else
                n_rot[l] = CW'(qr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vd <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_va <= i_quat.valid;
            r_vb <= r_va;
            r_vd <= {r_vd[ND-1:0], r_vb};
            r_ov <= r_vd[ND];
        end
        if (en) begin
            r_x <= i_quat.quat_x;
            r_y <= i_quat.quat_y;
            r_z <= i_quat.quat_z;
            r_w <= i_quat.quat_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_ww <= r_w * r_w;
            r_xy <= r_x * r_y;
            r_xz <= r_x * r_z;
            r_xw <= r_x * r_w;
            r_yz <= r_y * r_z;
            r_yw <= r_y * r_w;
            r_zw <= r_z * r_w;
            r_len[0] <= n_len;
            r_zl[0]  <= (n_len == '0);
            for (int l = 0; l < N_ENTRIES; l++) begin
                r_neg[0][l] <= n_num[l][NW-1];
                r_rem[0][l] <= RW'(n_num[l][NW-1] ? -n_num[l] : n_num[l]);
                r_q[0][l]   <= '0;
            end
            for (int s = 0; s < ND; s++) begin
                r_len[s+1] <= r_len[s];
                r_zl[s+1]  <= r_zl[s];
                r_neg[s+1] <= r_neg[s];
                for (int l = 0; l < N_ENTRIES; l++) begin
                    r_rem[s+1][l] <= n_rem[s+1][l];
                    r_q[s+1][l]   <= n_q[s+1][l];
                end
            end
            r_ozl <= r_zl[ND];
            for (int l = 0; l < N_ENTRIES; l++)
                r_rot[l] <= n_rot[l];
        end
    end

    assign o_rot.valid       = r_ov;
    assign o_rot.zero_length = r_ozl;
    assign o_rot.rot_00 = r_rot[0];
    assign o_rot.rot_01 = r_rot[1];
    assign o_rot.rot_02 = r_rot[2];
    assign o_rot.rot_10 = r_rot[3];
    assign o_rot.rot_11 = r_rot[4];
    assign o_rot.rot_12 = r_rot[5];
    assign o_rot.rot_20 = r_rot[6];
    assign o_rot.rot_21 = r_rot[7];
    assign o_rot.rot_22 = r_rot[8];

    // zero-length word must come out as the identity in rot_00, rot_01 and rot_11
    a_zero_ident: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ozl) |-> (r_rot[0] == CW'(ONE_Q) && r_rot[1] == '0 && r_rot[4] == CW'(ONE_Q)))
        else $error("zero length word not identity");
    // a stalled output must not let the last division stage advance into it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_rot.ready) |=> r_ov)
        else $error("output word dropped during stall");
    // diagonal entry rot_00 stays within plus or minus one
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_rot[0] <= $signed(CW'(ONE_Q)) && r_rot[0] >= -$signed(CW'(ONE_Q))))
        else $error("diagonal entry out of range");
    // a word in the last division stage moves out when the pipe advances
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_vd[ND]) |=> r_ov)
        else $error("word lost at output register");
endmodule
`default_nettype wire

// File: dv/tb.sv
// testbench for the quaternion to rotation matrix block
`timescale 1ns / 1ps
module tb;
    import qrm_pkg::*;

    localparam int CW = 16;
    localparam int FB = 14;
    localparam int N_RANDOM = 700;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;

    typedef logic signed [CW-1:0] comp_t;
    typedef struct packed {
        comp_t x, y, z, w;
    } quat_t;
    typedef struct packed {
        comp_t [N_ENTRIES-1:0] m;   // m[0] is rot_00 ... m[8] is rot_22
        logic zl;
    } matrix_t;
    typedef struct {
        quat_t q;
        logic has_fixed;
        matrix_t fixed;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    qrm_in_if #(.COMP_WIDTH(CW)) quat_ch ();
    qrm_out_if #(.COMP_WIDTH(CW)) rot_ch ();

    quaternion_to_rotation_matrix #(.COMP_WIDTH(CW), .FRAC_BITS(FB)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_quat(quat_ch.sink),
        .o_rot(rot_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    matrix_t expected_mats[$];
    int errors = 0;
    bit sending_done = 0;
    bit hold_long = 0;
    bit calm = 0;

    // rounded, saturated num * 2^FB / len, sign and magnitude
    function automatic comp_t div_round(longint num, longint len);
        longint mag, q, r;
        bit neg;
        neg = num < 0;
        mag = neg ? -num : num;
        q = (mag << FB) / len;
        r = (mag << FB) % len;
        if (2 * r >= len) q = q + 1;
        if (q > (longint'(1) << FB)) q = longint'(1) << FB;
        if (neg) q = -q;
        return comp_t'(q);
    endfunction

    function automatic matrix_t rotation_of(quat_t q);
        matrix_t res;
        longint x, y, z, w, l;
        x = q.x; y = q.y; z = q.z; w = q.w;
        l = x*x + y*y + z*z + w*w;
        if (l == 0) begin
            for (int k = 0; k < N_ENTRIES; k++)
                res.m[k] = IDENT_DIAG[k] ? comp_t'(1 << FB) : '0;
            res.zl = 1'b1;
            return res;
        end
        res.m[0] = div_round(x*x + w*w - y*y - z*z, l);
        res.m[1] = div_round(2 * (x*y + z*w), l);
        res.m[2] = div_round(2 * (x*z - y*w), l);
        res.m[3] = div_round(2 * (x*y - z*w), l);
        res.m[4] = div_round(y*y + w*w - x*x - z*z, l);
        res.m[5] = div_round(2 * (y*z + x*w), l);
        res.m[6] = div_round(2 * (x*z + y*w), l);
        res.m[7] = div_round(2 * (y*z - x*w), l);
        res.m[8] = div_round(z*z + w*w - x*x - y*y, l);
        res.zl = 1'b0;
        return res;
    endfunction

    function automatic matrix_t diag_mat(comp_t a, comp_t b, comp_t c, logic zl);
        matrix_t res;
        res.m = '0;
        res.m[0] = a; res.m[4] = b; res.m[8] = c;
        res.zl = zl;
        return res;
    endfunction

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return comp_t'(16'sh8000);
            1: return comp_t'(16'sh7fff);
            2: return '0;
            3: return comp_t'($urandom_range(0, 64)) - comp_t'(32);
            default: return comp_t'($urandom);
        endcase
    endfunction

    localparam comp_t ONE = comp_t'(1 << FB);
    stim_row_t directed[$];

    initial begin
        stim_row_t r;
        matrix_t fixed;
        quat_t q;
        int gap;
        int total;
        quat_ch.valid <= 1'b0;
        quat_ch.quat_x <= '0;
        quat_ch.quat_y <= '0;
        quat_ch.quat_z <= '0;
        quat_ch.quat_w <= '0;
        // zero length gives identity with the flag
        r.q = '0; r.has_fixed = 1; r.fixed = diag_mat(ONE, ONE, ONE, 1'b1);
        directed.push_back(r);
        // pure w gives identity, pure x/y/z give half-turns
        r.q = '{x: 0, y: 0, z: 0, w: ONE};
        r.fixed = diag_mat(ONE, ONE, ONE, 1'b0); directed.push_back(r);
        r.q = '{x: 16'sh8000, y: 0, z: 0, w: 0};
        r.fixed = diag_mat(ONE, -ONE, -ONE, 1'b0); directed.push_back(r);
        r.q = '{x: 0, y: 16'sh7fff, z: 0, w: 0};
        r.fixed = diag_mat(-ONE, ONE, -ONE, 1'b0); directed.push_back(r);
        r.q = '{x: 0, y: 0, z: 1, w: 0};
        r.fixed = diag_mat(-ONE, -ONE, ONE, 1'b0); directed.push_back(r);
        r.q = '{x: 0, y: 0, z: 0, w: 16'sh8000};
        r.fixed = diag_mat(ONE, ONE, ONE, 1'b0); directed.push_back(r);
        r.has_fixed = 0;
        r.q = '{x: 16'sh8000, y: 16'sh8000, z: 16'sh8000, w: 16'sh8000}; directed.push_back(r);
        r.q = '{x: 16'sh7fff, y: 16'sh7fff, z: 16'sh7fff, w: 16'sh7fff}; directed.push_back(r);
        r.q = '{x: 16'sh7fff, y: 16'sh8000, z: 16'sh7fff, w: 16'sh8000}; directed.push_back(r);
        r.q = '{x: 1, y: 1, z: 1, w: 1}; directed.push_back(r);
        r.q = '{x: -1, y: 1, z: -1, w: 0}; directed.push_back(r);
        r.q = '{x: 1, y: 2, z: 3, w: 4}; directed.push_back(r);
        r.q = '{x: 16'sh2d41, y: 0, z: 0, w: 16'sh2d41}; directed.push_back(r);
        r.q = '{x: 0, y: 16'shd2bf, z: 0, w: 16'sh2d41}; directed.push_back(r);
        r.q = '{x: 3, y: 0, z: 0, w: 1}; directed.push_back(r);
        r.q = '{x: 16'sh5555, y: 16'shaaaa, z: 16'sh00ff, w: 16'shff00}; directed.push_back(r);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        total = directed.size() + N_RANDOM;
        for (int i = 0; i < total; i++) begin
            if (i < directed.size()) begin
                q = directed[i].q;
            end else begin
                q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
            end
            if (i == total - 100) calm = 1;
            if (!calm && $urandom_range(0, 9) == 0) begin
                quat_ch.valid <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap) @(posedge i_clk);
            end
            if (i == directed.size() + 50) hold_long = 1;
            quat_ch.valid <= 1'b1;
            quat_ch.quat_x <= q.x;
            quat_ch.quat_y <= q.y;
            quat_ch.quat_z <= q.z;
            quat_ch.quat_w <= q.w;
            @(posedge i_clk);
            while (!quat_ch.ready) @(posedge i_clk);
            if (i < directed.size() && directed[i].has_fixed) begin
                fixed = directed[i].fixed;
                if (fixed != rotation_of(q)) begin
                    $display("%0t predictor disagrees on row %0d: typed %h model %h",
                             $time, i, fixed, rotation_of(q));
                    errors++;
                end
                expected_mats.push_back(fixed);
            end else begin
                expected_mats.push_back(rotation_of(q));
            end
        end
        quat_ch.valid <= 1'b0;
        sending_done = 1;
    end

    // result side: random stalls plus one long hold-off
    initial begin
        int gap;
        rot_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                hold_long = 0;
                rot_ch.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                rot_ch.ready <= 1'b0;
                gap = $urandom_range(1, 19);
                repeat (gap - 1) @(posedge i_clk);
            end else begin
                rot_ch.ready <= 1'b1;
            end
        end
    end

    // compare each matrix word with the oldest prediction
    always @(posedge i_clk) begin
        matrix_t got, exp_m;
        if (i_rst_n && rot_ch.valid && rot_ch.ready) begin
            got.m[0] = rot_ch.rot_00; got.m[1] = rot_ch.rot_01; got.m[2] = rot_ch.rot_02;
            got.m[3] = rot_ch.rot_10; got.m[4] = rot_ch.rot_11; got.m[5] = rot_ch.rot_12;
            got.m[6] = rot_ch.rot_20; got.m[7] = rot_ch.rot_21; got.m[8] = rot_ch.rot_22;
            got.zl = rot_ch.zero_length;
            if (expected_mats.size() == 0) begin
                $display("%0t unexpected matrix word: expected none actual %h", $time, got);
                errors++;
            end else begin
                exp_m = expected_mats.pop_front();
                for (int k = 0; k < N_ENTRIES; k++)
                    if (got.m[k] !== exp_m.m[k]) begin
                        $display("%0t rot_%0d%0d mismatch: expected %0d actual %0d",
                                 $time, k / 3, k % 3, exp_m.m[k], got.m[k]);
                        errors++;
                    end
                if (got.zl !== exp_m.zl) begin
                    $display("%0t zero_length mismatch: expected %b actual %b",
                             $time, exp_m.zl, got.zl);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge i_rst_n);
        while (!(sending_done && expected_mats.size() == 0)) begin
            @(posedge i_clk);
            if ((quat_ch.valid && quat_ch.ready) || (rot_ch.valid && rot_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t timeout with %0d words outstanding", $time, expected_mats.size());
                $display("FAIL");
                $finish;
            end
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_mats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: quaternion_to_rotation_matrix.f
sv/qrm_pkg.sv
sv/qrm_if.sv
sv/quaternion_to_rotation_matrix.sv
dv/tb.sv
